// File: design/bos_pkg.sv
// Shared types and constants for the per-class box overlap suppression block.
// Used by bos_store, bos_overlap and box_overlap_suppression; depends on nothing.
package bos_pkg;

  localparam int MAX_BOXES   = 64;
  localparam int NUM_CLASSES = 80;
  localparam int IDX_W       = $clog2(MAX_BOXES);
  localparam int CNT_W       = $clog2(MAX_BOXES + 1);

  localparam logic [15:0] THR_RESET = 16'd29491;

  // Edge coordinates at twice the scale: 2*center +- size
  localparam int EDGE_W  = 19;
  localparam int SIDE_W  = 17;
  localparam int INTER_W = 32;
  localparam int AREA_W  = 32;
  localparam int UNI_W   = 33;
  localparam int PROD_W  = UNI_W + SIDE_W;

  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
    logic [7:0]         class_id;
    logic [15:0]        score;
    logic               last_box;
  } bos_in_t;

  typedef struct packed {
    logic signed [15:0] out_center_x;
    logic signed [15:0] out_center_y;
    logic [14:0]        out_width;
    logic [14:0]        out_height;
    logic [7:0]         out_class;
    logic [15:0]        out_score;
    logic               out_last;
    logic               dropped_any;
  } bos_out_t;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [14:0]        w;
    logic [14:0]        h;
  } bos_geom_t;

  typedef struct packed {
    bos_geom_t   geom;
    logic [7:0]  cls;
    logic [15:0] score;
  } bos_entry_t;

  typedef struct packed {
    logic done;
    logic hit;
  } bos_ovl_res_t;

endpackage

// File: design/box_overlap_suppression.sv
// Per-class greedy overlap suppression. A box transfer is taken while idle;
// a last box starts the frame pass, whose busy time is set by one memory read
// port and one shared multiplier. Results leave as one-cycle out_valid strobes.
// Synchronous active-low reset clears count, masks, flags and sets the threshold.
module box_overlap_suppression (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bos_pkg::bos_in_t  in_data,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  output logic              out_valid,
  output bos_pkg::bos_out_t out_data
);
  import bos_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SEL, S_LOAD, S_LOADW, S_CHK_RD, S_CHK_EV, S_OVL, S_FLUSH
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 ovf_r;
  logic [15:0]          thr_r;
  logic [MAX_BOXES-1:0] keep_r, vis_r;
  logic [CNT_W-1:0]     scan_r;
  logic                 pend_r;
  logic [IDX_W-1:0]     pend_idx_r;
  logic                 best_vld_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [7:0]           best_cls_r;
  logic [15:0]          best_score_r;
  bos_entry_t           cand_r;
  logic [IDX_W-1:0]     cand_idx_r;
  logic                 hold_vld_r;
  bos_entry_t           hold_r;
  logic                 out_valid_r;
  bos_out_t             out_data_r;

  logic                 accept, cls_ok, mem_we;
  logic [IDX_W-1:0]     rd_addr;
  bos_entry_t           wr_entry, rd_entry;
  logic                 is_before, take, ovl_start;
  bos_ovl_res_t         ovl_res;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign cls_ok = ({1'b0, in_data.class_id} < 9'(NUM_CLASSES));
  assign mem_we = accept && cls_ok && (cnt_r < CNT_W'(MAX_BOXES));

  assign wr_entry = '{geom: '{cx: in_data.center_x, cy: in_data.center_y,
                              w: in_data.box_width, h: in_data.box_height},
                      cls: in_data.class_id, score: in_data.score};

  // Read address: chosen box while loading, scan pointer otherwise
  always_comb begin
    unique case (state_r)
      S_LOAD:  rd_addr = best_idx_r;
      default: rd_addr = scan_r[IDX_W-1:0];
    endcase
  end

  bos_store u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  // Visiting order: lower class first, then higher score, then arrival
  assign is_before = (rd_entry.cls < best_cls_r) ||
                     ((rd_entry.cls == best_cls_r) && (rd_entry.score > best_score_r));
  assign take      = pend_r && !vis_r[pend_idx_r] && (!best_vld_r || is_before);
  assign ovl_start = (state_r == S_CHK_EV) && (scan_r != cnt_r) &&
                     keep_r[scan_r[IDX_W-1:0]] && (rd_entry.cls == cand_r.cls);

  bos_overlap u_overlap (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ovl_start),
    .geom_a    (rd_entry.geom),
    .geom_b    (cand_r.geom),
    .threshold (thr_r),
    .res       (ovl_res)
  );

  // Sequencer: store, select next box, check against kept boxes, emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      thr_r       <= THR_RESET;
      keep_r      <= '0;
      vis_r       <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      best_vld_r  <= 1'b0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (mem_we) begin
              cnt_r <= cnt_r + 1'b1;
            end else if (cls_ok) begin
              ovf_r <= 1'b1;
            end
            if (in_data.last_box) begin
              scan_r     <= '0;
              pend_r     <= 1'b0;
              best_vld_r <= 1'b0;
              state_r    <= S_SEL;
            end
          end
        end
        S_SEL: begin
          // Issue one read and compare the previous one each cycle
          if (scan_r != cnt_r) begin
            pend_r     <= 1'b1;
            pend_idx_r <= scan_r[IDX_W-1:0];
            scan_r     <= scan_r + 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (take) begin
            best_vld_r   <= 1'b1;
            best_idx_r   <= pend_idx_r;
            best_cls_r   <= rd_entry.cls;
            best_score_r <= rd_entry.score;
          end
          if (scan_r == cnt_r && !pend_r) begin
            if (best_vld_r) begin
              vis_r[best_idx_r] <= 1'b1;
              cand_idx_r        <= best_idx_r;
              state_r           <= S_LOAD;
            end else begin
              state_r <= S_FLUSH;
            end
          end
        end
        S_LOAD: state_r <= S_LOADW;
        S_LOADW: begin
          cand_r  <= rd_entry;
          scan_r  <= '0;
          state_r <= S_CHK_RD;
        end
        S_CHK_RD: begin
          if (scan_r == cnt_r) begin
            // No kept box suppresses it: keep and emit the previous one
            keep_r[cand_idx_r] <= 1'b1;
            if (hold_vld_r) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '{out_center_x: hold_r.geom.cx, out_center_y: hold_r.geom.cy,
                               out_width: hold_r.geom.w, out_height: hold_r.geom.h,
                               out_class: hold_r.cls, out_score: hold_r.score,
                               out_last: 1'b0, dropped_any: ovf_r};
            end
            hold_r     <= cand_r;
            hold_vld_r <= 1'b1;
            scan_r     <= '0;
            pend_r     <= 1'b0;
            best_vld_r <= 1'b0;
            state_r    <= S_SEL;
          end else begin
            state_r <= S_CHK_EV;
          end
        end
        S_CHK_EV: begin
          if (ovl_start) begin
            state_r <= S_OVL;
          end else begin
            scan_r  <= scan_r + 1'b1;
            state_r <= S_CHK_RD;
          end
        end
        S_OVL: begin
          if (ovl_res.done) begin
            if (ovl_res.hit) begin
              // Drop the candidate
              scan_r     <= '0;
              pend_r     <= 1'b0;
              best_vld_r <= 1'b0;
              state_r    <= S_SEL;
            end else begin
              scan_r  <= scan_r + 1'b1;
              state_r <= S_CHK_RD;
            end
          end
        end
        S_FLUSH: begin
          if (hold_vld_r) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{out_center_x: hold_r.geom.cx, out_center_y: hold_r.geom.cy,
                             out_width: hold_r.geom.w, out_height: hold_r.geom.h,
                             out_class: hold_r.cls, out_score: hold_r.score,
                             out_last: 1'b1, dropped_any: ovf_r};
          end
          hold_vld_r <= 1'b0;
          cnt_r      <= '0;
          ovf_r      <= 1'b0;
          keep_r     <= '0;
          vis_r      <= '0;
          state_r    <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BOXES))
    else $error("box count above capacity");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_last |-> busy)
    else $error("non-final result while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_last |-> !busy ##1 !out_valid)
    else $error("activity after final result");

  a_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.last_box |=> busy)
    else $error("last box did not start the frame pass");
`endif

endmodule

// File: design/bos_store.sv
// Box storage: one write port, one registered read port.
// Depends on bos_pkg for the entry type and depth.
module bos_store (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [bos_pkg::IDX_W-1:0]     wr_addr,
  input  bos_pkg::bos_entry_t           wr_data,
  input  logic [bos_pkg::IDX_W-1:0]     rd_addr,
  output bos_pkg::bos_entry_t           rd_data
);
  import bos_pkg::*;

  bos_entry_t mem [MAX_BOXES];
  bos_entry_t rd_data_r;

  // Write incoming boxes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/bos_overlap.sv
// Overlap test of two boxes: intersection * 2^16 > threshold * union.
// One shared multiplier stepped by a small sequencer; depends on bos_pkg.
module bos_overlap (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  bos_pkg::bos_geom_t    geom_a,
  input  bos_pkg::bos_geom_t    geom_b,
  input  logic [15:0]           threshold,
  output bos_pkg::bos_ovl_res_t res
);
  import bos_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EDGE, S_MUL_I, S_MUL_A, S_MUL_B, S_UNI, S_MUL_T, S_CMP
  } state_t;

  state_t              state_r;
  bos_geom_t           ga_r, gb_r;
  logic [SIDE_W-1:0]   dx_r, dy_r;
  logic [INTER_W-1:0]  inter_r;
  logic [AREA_W-1:0]   area_a_r;
  logic [UNI_W-1:0]    uni_r;
  logic [PROD_W-1:0]   prod_r;
  bos_ovl_res_t        res_r;

  logic signed [EDGE_W-1:0] a_l, a_r, a_t, a_b, b_l, b_r, b_t, b_b;
  logic signed [EDGE_W-1:0] left, right, top, bottom, dx, dy;
  logic                     apart;
  logic [UNI_W-1:0]         mul_a;
  logic [SIDE_W-1:0]        mul_b;
  logic [PROD_W-1:0]        prod;

  // Edges at twice the scale
  assign a_l = $signed({{2{ga_r.cx[15]}}, ga_r.cx, 1'b0}) - $signed({4'b0, ga_r.w});
  assign a_r = $signed({{2{ga_r.cx[15]}}, ga_r.cx, 1'b0}) + $signed({4'b0, ga_r.w});
  assign a_t = $signed({{2{ga_r.cy[15]}}, ga_r.cy, 1'b0}) - $signed({4'b0, ga_r.h});
  assign a_b = $signed({{2{ga_r.cy[15]}}, ga_r.cy, 1'b0}) + $signed({4'b0, ga_r.h});
  assign b_l = $signed({{2{gb_r.cx[15]}}, gb_r.cx, 1'b0}) - $signed({4'b0, gb_r.w});
  assign b_r = $signed({{2{gb_r.cx[15]}}, gb_r.cx, 1'b0}) + $signed({4'b0, gb_r.w});
  assign b_t = $signed({{2{gb_r.cy[15]}}, gb_r.cy, 1'b0}) - $signed({4'b0, gb_r.h});
  assign b_b = $signed({{2{gb_r.cy[15]}}, gb_r.cy, 1'b0}) + $signed({4'b0, gb_r.h});

  assign left   = (a_l > b_l) ? a_l : b_l;
  assign right  = (a_r < b_r) ? a_r : b_r;
  assign top    = (a_t > b_t) ? a_t : b_t;
  assign bottom = (a_b < b_b) ? a_b : b_b;
  assign dx     = right - left;
  assign dy     = bottom - top;
  assign apart  = (top > bottom) || (left > right);

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL_I: begin
        mul_a = UNI_W'(dx_r);
        mul_b = dy_r;
      end
      S_MUL_A: begin
        mul_a = UNI_W'(ga_r.w);
        mul_b = SIDE_W'(ga_r.h);
      end
      S_MUL_B: begin
        mul_a = UNI_W'(gb_r.w);
        mul_b = SIDE_W'(gb_r.h);
      end
      S_MUL_T: begin
        mul_a = uni_r;
        mul_b = SIDE_W'(threshold);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Sequence the steps of one test
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= '0;
    end else begin
      res_r  <= '0;
      prod_r <= prod;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            ga_r    <= geom_a;
            gb_r    <= geom_b;
            state_r <= S_EDGE;
          end
        end
        S_EDGE: begin
          dx_r <= dx[SIDE_W-1:0];
          dy_r <= dy[SIDE_W-1:0];
          if (apart) begin
            res_r   <= '{done: 1'b1, hit: 1'b0};
            state_r <= S_IDLE;
          end else begin
            state_r <= S_MUL_I;
          end
        end
        S_MUL_I: state_r <= S_MUL_A;
        S_MUL_A: begin
          inter_r <= prod_r[INTER_W-1:0];
          state_r <= S_MUL_B;
        end
        S_MUL_B: begin
          area_a_r <= {prod_r[AREA_W-3:0], 2'b00};
          state_r  <= S_UNI;
        end
        S_UNI: begin
          uni_r <= {1'b0, area_a_r} + {1'b0, prod_r[AREA_W-3:0], 2'b00}
                   - {1'b0, inter_r};
          state_r <= S_MUL_T;
        end
        S_MUL_T: state_r <= S_CMP;
        S_CMP: begin
          res_r   <= '{done: 1'b1,
                       hit: ({2'b00, inter_r, 16'h0000} > prod_r)};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res = res_r;

endmodule

// File: tb/box_overlap_suppression_tb.sv
// Testbench for box_overlap_suppression: drives frames of boxes, predicts the
// kept boxes with a per-class greedy suppression model and checks each result.
// Depends on bos_pkg and the box_overlap_suppression RTL.
`timescale 1ns / 1ps

module box_overlap_suppression_tb;
  import bos_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  bos_in_t     in_data;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        out_valid;
  bos_out_t    out_data;

  // Predictor state: boxes of the current frame, overflow and threshold
  bos_in_t     frame_boxes[MAX_BOXES];
  int          frame_count;
  bit          frame_dropped;
  logic [15:0] iou_threshold;
  bos_out_t    kept_boxes[$];

  int          error_count;
  int          boxes_sent;
  int          cycle_count;
  bit          no_gaps;

  box_overlap_suppression dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // True when the IoU of boxes a and b is strictly above the threshold
  function automatic bit boxes_overlap(input bos_in_t a, input bos_in_t b);
    longint left, right, top, bottom;
    longint a_l, a_r, a_t, a_b, b_l, b_r, b_t, b_b;
    longint unsigned inter, area_a, area_b, uni;
    a_l    = 2 * longint'(a.center_x) - longint'(a.box_width);
    a_r    = 2 * longint'(a.center_x) + longint'(a.box_width);
    a_t    = 2 * longint'(a.center_y) - longint'(a.box_height);
    a_b    = 2 * longint'(a.center_y) + longint'(a.box_height);
    b_l    = 2 * longint'(b.center_x) - longint'(b.box_width);
    b_r    = 2 * longint'(b.center_x) + longint'(b.box_width);
    b_t    = 2 * longint'(b.center_y) - longint'(b.box_height);
    b_b    = 2 * longint'(b.center_y) + longint'(b.box_height);
    left   = (a_l > b_l) ? a_l : b_l;
    right  = (a_r < b_r) ? a_r : b_r;
    top    = (a_t > b_t) ? a_t : b_t;
    bottom = (a_b < b_b) ? a_b : b_b;
    if (top > bottom || left > right) return 1'b0;
    inter  = longint'(right - left) * longint'(bottom - top);
    area_a = 4 * longint'(a.box_width) * longint'(a.box_height);
    area_b = 4 * longint'(b.box_width) * longint'(b.box_height);
    uni    = area_a + area_b - inter;
    return (inter << 16) > longint'(iou_threshold) * uni;
  endfunction

  // Visiting order: ascending class, falling score, then arrival
  function automatic bit visits_first(input int p, input int q);
    if (frame_boxes[p].class_id != frame_boxes[q].class_id)
      return frame_boxes[p].class_id < frame_boxes[q].class_id;
    if (frame_boxes[p].score != frame_boxes[q].score)
      return frame_boxes[p].score > frame_boxes[q].score;
    return p < q;
  endfunction

  // Store one accepted box; on the last box run suppression and queue kept boxes
  task automatic predict_box(input bos_in_t b);
    int       order[MAX_BOXES];
    bit       kept[MAX_BOXES];
    int       j, n;
    bit       keep;
    bos_out_t r;
    if (b.class_id < NUM_CLASSES) begin
      if (frame_count < MAX_BOXES) begin
        frame_boxes[frame_count] = b;
        frame_count++;
      end else begin
        frame_dropped = 1'b1;
      end
    end
    if (!b.last_box) return;
    for (int i = 0; i < frame_count; i++) begin
      j = i;
      while (j > 0 && visits_first(i, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    n = 0;
    for (int i = 0; i < frame_count; i++) begin
      keep = 1'b1;
      kept[order[i]] = 1'b0;
      for (int k = 0; k < i && keep; k++)
        if (kept[order[k]] &&
            frame_boxes[order[k]].class_id == frame_boxes[order[i]].class_id &&
            boxes_overlap(frame_boxes[order[k]], frame_boxes[order[i]]))
          keep = 1'b0;
      if (keep) begin
        kept[order[i]]   = 1'b1;
        r.out_center_x   = frame_boxes[order[i]].center_x;
        r.out_center_y   = frame_boxes[order[i]].center_y;
        r.out_width      = frame_boxes[order[i]].box_width;
        r.out_height     = frame_boxes[order[i]].box_height;
        r.out_class      = frame_boxes[order[i]].class_id;
        r.out_score      = frame_boxes[order[i]].score;
        r.out_last       = 1'b0;
        r.dropped_any    = frame_dropped;
        kept_boxes       = {kept_boxes, r};
        n++;
      end
    end
    if (n > 0) kept_boxes[kept_boxes.size()-1].out_last = 1'b1;
    frame_count   = 0;
    frame_dropped = 1'b0;
  endtask

  // Send one box: optional gap, then hold start until the transfer
  task automatic send_box(input bos_in_t b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    predict_box(b);
    boxes_sent++;
  endtask

  // Drop start and wait until the block is idle with nothing outstanding
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (kept_boxes.size() != 0 || busy);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    iou_threshold = value;
  endtask

  function automatic bos_in_t make_box(input int cx, input int cy, input int w, input int h,
                                       input int cls, input int score, input bit last);
    bos_in_t b;
    b.center_x   = cx[15:0];
    b.center_y   = cy[15:0];
    b.box_width  = w[14:0];
    b.box_height = h[14:0];
    b.class_id   = cls[7:0];
    b.score      = score[15:0];
    b.last_box   = last;
    return b;
  endfunction

  // Field extremes, one frame
  task automatic test_extremes();
    send_box(make_box(-32768, 32767, 32767, 32767, 0, 65535, 0));
    send_box(make_box(32767, -32768, 32767, 0, NUM_CLASSES - 1, 0, 0));
    send_box(make_box(0, 0, 0, 32767, 1, 1, 1));
  endtask

  // Identical, disjoint, partly overlapping, zero-area and equal-score boxes
  task automatic test_overlap_cases();
    send_box(make_box(4096, 4096, 2048, 2048, 3, 40000, 0));
    send_box(make_box(4096, 4096, 2048, 2048, 3, 50000, 0));
    send_box(make_box(-8192, -8192, 1024, 1024, 3, 60000, 0));
    send_box(make_box(4096 + 1024, 4096, 1024, 2048, 3, 45000, 0));
    send_box(make_box(0, 0, 0, 0, 5, 100, 0));
    send_box(make_box(0, 0, 0, 0, 5, 100, 0));
    send_box(make_box(100, 100, 500, 500, 7, 300, 0));
    send_box(make_box(100, 100, 500, 500, 7, 300, 0));
    send_box(make_box(110, 90, 500, 510, 7, 300, 1));
  endtask

  // Out-of-range classes are ignored but still end a frame; empty frame
  task automatic test_out_of_range();
    send_box(make_box(10, 10, 100, 100, 2, 900, 0));
    send_box(make_box(10, 10, 100, 100, 255, 900, 1));
    send_box(make_box(10, 10, 100, 100, NUM_CLASSES, 900, 1));
  endtask

  // More boxes than the store holds; the ending box is itself dropped
  task automatic test_overflow();
    for (int i = 0; i <= MAX_BOXES; i++)
      send_box(make_box($urandom_range(0, 8000), $urandom_range(0, 8000), $urandom_range(200, 3000),
                        $urandom_range(200, 3000), $urandom_range(0, 2), $urandom(),
                        i == MAX_BOXES));
  endtask

  // Random frames: mostly clustered well-formed boxes, some wide-range noise
  task automatic test_random_frames(input int target);
    int n, base_x, base_y, cls, w, h;
    bos_in_t b;
    while (boxes_sent < target) begin
      n       = ($urandom_range(0, 14) == 0) ? $urandom_range(40, MAX_BOXES + 2)
                                             : $urandom_range(1, 8);
      no_gaps = ($urandom_range(0, 3) == 0);
      base_x  = $urandom_range(0, 16000) - 8000;
      base_y  = $urandom_range(0, 16000) - 8000;
      for (int i = 0; i < n; i++) begin
        cls = $urandom_range(0, 3);
        w   = $urandom_range(500, 3000);
        h   = $urandom_range(500, 3000);
        b   = make_box(base_x + $urandom_range(0, 800), base_y + $urandom_range(0, 800), w, h,
                       cls, ($urandom_range(0, 3) == 0) ? 30000 : $urandom(), i == n - 1);
        if ($urandom_range(0, 9) == 0) begin
          b.center_x   = 16'($urandom());
          b.center_y   = 16'($urandom());
          b.box_width  = 15'($urandom());
          b.box_height = 15'($urandom());
          b.class_id   = 8'($urandom());
        end
        send_box(b);
      end
    end
    no_gaps = 1'b0;
  endtask

  // Compare each result with the oldest kept-box expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (kept_boxes.size() == 0) begin
        report_mismatch("result with no expected box");
      end else begin
        bos_out_t e;
        e = kept_boxes.pop_front();
        if (out_data.out_center_x !== e.out_center_x) report_mismatch("out_center_x");
        if (out_data.out_center_y !== e.out_center_y) report_mismatch("out_center_y");
        if (out_data.out_width !== e.out_width)       report_mismatch("out_width");
        if (out_data.out_height !== e.out_height)     report_mismatch("out_height");
        if (out_data.out_class !== e.out_class)       report_mismatch("out_class");
        if (out_data.out_score !== e.out_score)       report_mismatch("out_score");
        if (out_data.out_last !== e.out_last)         report_mismatch("out_last");
        if (out_data.dropped_any !== e.dropped_any)   report_mismatch("dropped_any");
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    cycle_count   = 0;
    error_count   = 0;
    boxes_sent    = 0;
    frame_count   = 0;
    frame_dropped = 1'b0;
    no_gaps       = 1'b0;
    iou_threshold = THR_RESET;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_data       = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_overlap_cases();
    test_out_of_range();
    test_overflow();
    write_threshold(16'd0);
    test_overlap_cases();
    test_random_frames(boxes_sent + 25);
    write_threshold(16'hFFFF);
    test_overlap_cases();
    test_random_frames(boxes_sent + 25);
    write_threshold(16'd32768);
    test_random_frames(boxes_sent + 30);
    write_threshold(16'($urandom()));
    test_random_frames(boxes_sent + 30);
    write_threshold(THR_RESET);
    test_random_frames(boxes_sent + 25);

    settle();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
